/* hdl/u8cpc_pkg.sv */
// ============================================================================
// u8cpc_pkg
// Shared types, constants and byte classifier for the UTF-8 code point counter.
// ============================================================================
package u8cpc_pkg;

    // Default tally width; tallies and total saturate at all ones.
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int BYTE_WIDTH = 8;
    localparam int OWED_WIDTH = 2;

    // Bit-pattern prefixes after the matching right shift.
    localparam logic [7:0] ASCII_MASK   = 8'h80;
    localparam logic [2:0] LEAD2_PREFIX = 3'h6;   // 110xxxxx
    localparam logic [3:0] LEAD3_PREFIX = 4'hE;   // 1110xxxx
    localparam logic [4:0] LEAD4_PREFIX = 5'h1E;  // 11110xxx
    localparam logic [1:0] CONT_PREFIX  = 2'h2;   // 10xxxxxx

    localparam logic [OWED_WIDTH-1:0] OWED_NONE  = 2'd0;
    localparam logic [OWED_WIDTH-1:0] OWED_LEAD2 = 2'd1;
    localparam logic [OWED_WIDTH-1:0] OWED_LEAD3 = 2'd2;
    localparam logic [OWED_WIDTH-1:0] OWED_LEAD4 = 2'd3;

    localparam logic [BYTE_WIDTH-1:0] TERMINATOR = 8'h00;

    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_CONT,
        CLS_ILLEGAL
    } byte_class_t;

    function automatic byte_class_t classify(input logic [BYTE_WIDTH-1:0] b);
        byte_class_t c;
        if ((b & ASCII_MASK) == 8'h00) begin
            c = CLS_ASCII;
        end
        else if (b[7:5] == LEAD2_PREFIX) begin
            c = CLS_LEAD2;
        end
        else if (b[7:4] == LEAD3_PREFIX) begin
            c = CLS_LEAD3;
        end
        else if (b[7:3] == LEAD4_PREFIX) begin
            c = CLS_LEAD4;
        end
        else if (b[7:6] == CONT_PREFIX) begin
            c = CLS_CONT;
        end
        else begin
            c = CLS_ILLEGAL;
        end
        return c;
    endfunction

endpackage

/* hdl/u8cpc_byte_if.sv */
// ============================================================================
// u8cpc_byte_if
// Valid/ready channel carrying one byte of the UTF-8 string per transaction.
// ============================================================================
interface u8cpc_byte_if;

    logic                              valid;
    logic                              ready;
    logic [u8cpc_pkg::BYTE_WIDTH-1:0]  text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink   (input valid, input text_byte, output ready);

endinterface

/* hdl/u8cpc_result_if.sv */
// ============================================================================
// u8cpc_result_if
// Valid/ready channel carrying the running tallies, one result per transaction.
// ============================================================================
interface u8cpc_result_if #(
    parameter int COUNT_WIDTH = u8cpc_pkg::COUNT_WIDTH_DEF
);

    logic                              valid;
    logic                              ready;
    logic [COUNT_WIDTH-1:0]            one_byte_count;
    logic [COUNT_WIDTH-1:0]            two_byte_count;
    logic [COUNT_WIDTH-1:0]            three_byte_count;
    logic [COUNT_WIDTH-1:0]            four_byte_count;
    logic [COUNT_WIDTH-1:0]            total_count;
    logic [u8cpc_pkg::OWED_WIDTH-1:0]  owed_continuations;
    logic                              halted;
    logic                              string_end;

    modport source (
        output valid, output one_byte_count, output two_byte_count,
        output three_byte_count, output four_byte_count, output total_count,
        output owed_continuations, output halted, output string_end,
        input  ready
    );
    modport sink (
        input  valid, input one_byte_count, input two_byte_count,
        input  three_byte_count, input four_byte_count, input total_count,
        input  owed_continuations, input halted, input string_end,
        output ready
    );

endinterface

/* hdl/utf8_code_point_counter_core.sv */
// ============================================================================
// utf8_code_point_counter_core
// Counts UTF-8 sequences by length over a zero-terminated byte stream.
// ============================================================================
//
//  Channel     Modport  Payload                                     Per xact
//  ----------  -------  ------------------------------------------  ---------
//  byte_in     sink     text_byte[7:0]                               one byte
//  result_out  source   four tallies, total, owed, halted, end flag  one result
//
//  Throughput is one byte per cycle while the result side keeps accepting. The
//  byte is captured in an input register, then classified and applied to the
//  tally registers while the result register is loaded alongside them.
//  The result register parts the two sides; a stalled result only holds the
//  input stage once the input register is also full.
//  rst_n (async, active low) clears the pipeline valids and all counters.
//  A zero byte reports the final values and clears the counters behind it.
//
module utf8_code_point_counter_core #(
    parameter int COUNT_WIDTH = u8cpc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    u8cpc_byte_if.sink              byte_in,
    u8cpc_result_if.source          result_out
);

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic                               in_valid_reg;
    logic [u8cpc_pkg::BYTE_WIDTH-1:0]   in_byte_reg;
    logic                               advance;

    // Stage 1 moves into the result register when the result slot is free.
    assign advance       = in_valid_reg && (!result_out.valid || result_out.ready);
    assign byte_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            in_valid_reg <= byte_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            in_byte_reg <= byte_in.text_byte;
        end
    end

    // ------------------------------------------------------------------
    // Scan state
    // ------------------------------------------------------------------
    logic [COUNT_WIDTH-1:0]             single_reg, single_next;
    logic [COUNT_WIDTH-1:0]             double_reg, double_next;
    logic [COUNT_WIDTH-1:0]             triple_reg, triple_next;
    logic [COUNT_WIDTH-1:0]             quad_reg,   quad_next;
    logic [COUNT_WIDTH-1:0]             total_reg,  total_next;
    logic [u8cpc_pkg::OWED_WIDTH-1:0]   owed_reg,   owed_next;
    logic                               stop_reg,   stop_next;

    // Values after this byte, before the terminator clear.
    logic [COUNT_WIDTH-1:0]             single_upd, double_upd, triple_upd, quad_upd;
    logic [COUNT_WIDTH-1:0]             total_upd;
    logic [u8cpc_pkg::OWED_WIDTH-1:0]   owed_upd;
    logic                               stop_upd;
    logic                               bumped;
    logic                               is_end;
    u8cpc_pkg::byte_class_t             byte_class;

    assign is_end     = (in_byte_reg == u8cpc_pkg::TERMINATOR);
    assign byte_class = u8cpc_pkg::classify(in_byte_reg);

    always_comb
    begin
        single_upd = single_reg;
        double_upd = double_reg;
        triple_upd = triple_reg;
        quad_upd   = quad_reg;
        owed_upd   = owed_reg;
        stop_upd   = stop_reg;
        bumped     = 1'b0;

        if (!is_end && !stop_reg)
        begin
            unique case (byte_class)
                u8cpc_pkg::CLS_ASCII:
                begin
                    if (owed_reg != u8cpc_pkg::OWED_NONE)
                    begin
                        stop_upd = 1'b1;
                    end
                    else if (single_reg != '1)
                    begin
                        single_upd = single_reg + 1'b1;
                        bumped     = 1'b1;
                    end
                end
                u8cpc_pkg::CLS_LEAD2:
                begin
                    if (owed_reg != u8cpc_pkg::OWED_NONE)
                    begin
                        stop_upd = 1'b1;
                    end
                    else
                    begin
                        owed_upd = u8cpc_pkg::OWED_LEAD2;
                        if (double_reg != '1)
                        begin
                            double_upd = double_reg + 1'b1;
                            bumped     = 1'b1;
                        end
                    end
                end
                u8cpc_pkg::CLS_LEAD3:
                begin
                    if (owed_reg != u8cpc_pkg::OWED_NONE)
                    begin
                        stop_upd = 1'b1;
                    end
                    else
                    begin
                        owed_upd = u8cpc_pkg::OWED_LEAD3;
                        if (triple_reg != '1)
                        begin
                            triple_upd = triple_reg + 1'b1;
                            bumped     = 1'b1;
                        end
                    end
                end
                u8cpc_pkg::CLS_LEAD4:
                begin
                    if (owed_reg != u8cpc_pkg::OWED_NONE)
                    begin
                        stop_upd = 1'b1;
                    end
                    else
                    begin
                        owed_upd = u8cpc_pkg::OWED_LEAD4;
                        if (quad_reg != '1)
                        begin
                            quad_upd = quad_reg + 1'b1;
                            bumped   = 1'b1;
                        end
                    end
                end
                u8cpc_pkg::CLS_CONT:
                begin
                    if (owed_reg == u8cpc_pkg::OWED_NONE)
                    begin
                        stop_upd = 1'b1;
                    end
                    else
                    begin
                        owed_upd = owed_reg - 1'b1;
                    end
                end
                default:
                begin
                    stop_upd = 1'b1;
                end
            endcase
        end

        // The sum grows by at most one per byte, so a saturating increment
        // tracks min(sum, max) exactly without a four-way adder.
        total_upd = (bumped && total_reg != '1) ? total_reg + 1'b1 : total_reg;
    end

    always_comb
    begin
        if (is_end)
        begin
            single_next = '0;
            double_next = '0;
            triple_next = '0;
            quad_next   = '0;
            total_next  = '0;
            owed_next   = u8cpc_pkg::OWED_NONE;
            stop_next   = 1'b0;
        end
        else
        begin
            single_next = single_upd;
            double_next = double_upd;
            triple_next = triple_upd;
            quad_next   = quad_upd;
            total_next  = total_upd;
            owed_next   = owed_upd;
            stop_next   = stop_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            single_reg <= '0;
            double_reg <= '0;
            triple_reg <= '0;
            quad_reg   <= '0;
            total_reg  <= '0;
            owed_reg   <= u8cpc_pkg::OWED_NONE;
            stop_reg   <= 1'b0;
        end
        else if (advance)
        begin
            single_reg <= single_next;
            double_reg <= double_next;
            triple_reg <= triple_next;
            quad_reg   <= quad_next;
            total_reg  <= total_next;
            owed_reg   <= owed_next;
            stop_reg   <= stop_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                               out_valid_reg;
    logic [COUNT_WIDTH-1:0]             out_single_reg, out_double_reg;
    logic [COUNT_WIDTH-1:0]             out_triple_reg, out_quad_reg, out_total_reg;
    logic [u8cpc_pkg::OWED_WIDTH-1:0]   out_owed_reg;
    logic                               out_halted_reg;
    logic                               out_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Terminator reports the pre-clear values.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_single_reg <= single_upd;
            out_double_reg <= double_upd;
            out_triple_reg <= triple_upd;
            out_quad_reg   <= quad_upd;
            out_total_reg  <= total_upd;
            out_owed_reg   <= owed_upd;
            out_halted_reg <= stop_upd;
            out_end_reg    <= is_end;
        end
    end

    assign result_out.valid              = out_valid_reg;
    assign result_out.one_byte_count     = out_single_reg;
    assign result_out.two_byte_count     = out_double_reg;
    assign result_out.three_byte_count   = out_triple_reg;
    assign result_out.four_byte_count    = out_quad_reg;
    assign result_out.total_count        = out_total_reg;
    assign result_out.owed_continuations = out_owed_reg;
    assign result_out.halted             = out_halted_reg;
    assign result_out.string_end         = out_end_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_end |=> total_reg == '0 && owed_reg == u8cpc_pkg::OWED_NONE && !stop_reg)
        else $error("terminator did not clear scan state");

    a_stop_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        advance && stop_reg && !is_end |=> stop_reg && $stable(total_reg) && $stable(owed_reg))
        else $error("state changed after a malformed byte");

    a_total_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        single_reg <= total_reg && double_reg <= total_reg &&
        triple_reg <= total_reg && quad_reg <= total_reg)
        else $error("total below a tally");

    a_advance_loads: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced byte produced no result");

endmodule
